// ===== hdl/mfs_pkg.sv =====
// Shared types, constants and helpers for the monochrome frame buffer with serial scanout.
// No dependencies; the top level and mfs_addr import this package, mfs_ram does not.
package mfs_pkg;

    localparam int SCREEN_WIDTH  = 128;
    localparam int SCREEN_HEIGHT = 64;
    localparam int STORE_AW      = 10;            // 1024 bytes
    localparam int BYTE_W        = 8;

    localparam logic [5:0] LAST_STEP = 6'd33;     // two commands then 32 data bytes
    localparam logic [4:0] LAST_ROW  = 5'd31;
    localparam logic [5:0] STEP_ROW  = 6'd0;
    localparam logic [5:0] STEP_COL  = 6'd1;
    localparam logic [5:0] DATA_BASE = 6'd2;

    localparam logic [7:0] SYNC_CMD  = 8'hF8;
    localparam logic [7:0] SYNC_DATA = 8'hFA;
    localparam logic [7:0] ROW_CMD   = 8'h80;
    localparam logic [7:0] COL_CMD   = 8'h80;

    localparam logic [1:0] ROT_0   = 2'd0;
    localparam logic [1:0] ROT_90  = 2'd1;
    localparam logic [1:0] ROT_180 = 2'd2;
    localparam logic [1:0] ROT_270 = 2'd3;

    localparam logic [1:0] REG_ROTATION = 2'd0;
    localparam logic [1:0] REG_INVERT   = 2'd1;
    localparam logic [1:0] REG_SLEEPING = 2'd2;

    localparam logic MODE_PIXEL   = 1'b0;
    localparam logic MODE_REFRESH = 1'b1;

    typedef struct packed {
        logic       mode;
        logic [6:0] pos_x;
        logic [6:0] pos_y;
        logic       colour;
    } in_item_t;

    typedef struct packed {
        logic [23:0] frame_word;
        logic        is_command;
        logic        refresh_done;
    } out_item_t;

    typedef struct packed {
        logic                in_bounds;
        logic [STORE_AW-1:0] idx;
        logic [2:0]          bit_pos;
    } pix_loc_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PIX_WR,
        ST_EMIT
    } state_t;

    function automatic logic [23:0] frame_of(input logic [7:0] sync, input logic [7:0] b);
        frame_of = {sync, b[7:4], 4'b0000, b[3:0], 4'b0000};
    endfunction

endpackage

// ===== hdl/mono_framebuffer_serial_scanout.sv =====
// Top level: control sequencer, refresh position, configuration and output register.
// Depends on mfs_pkg, mfs_addr and mfs_ram.
//
//  channel | signals                       | payload
//  --------+-------------------------------+------------------------------------
//  input   | in_valid / in_ready           | in_data   (mode, pos_x, pos_y, colour)
//  output  | out_valid / out_ready         | out_data  (frame_word, is_command, refresh_done)
//  config  | cfg_we, cfg_index             | cfg_data  (rotation, invert_colour, sleeping)
//
// A beat that is acted on is handled in two steps: accept plus memory read, then write-back or
// load of the output register; the single memory port pair sets this split.
// After reset the 1024-byte store is cleared one byte per cycle, so in_ready stays low
// until the clear is done; config writes are taken meanwhile.
// A pending result waits for a free output register; the next beat is accepted while a
// finished result sits there. Beats taken asleep, and out-of-bounds writes, give no result.
module mono_framebuffer_serial_scanout (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  mfs_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output mfs_pkg::out_item_t out_data,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [1:0]         cfg_data
);
    import mfs_pkg::*;

    state_t state_reg, state_next;

    logic [STORE_AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic [1:0]          rotation_reg;
    logic                invert_reg;
    logic                sleep_reg;
    logic [4:0]          scan_row_reg, scan_row_next;
    logic [5:0]          scan_step_reg, scan_step_next;
    logic                out_valid_reg, out_valid_next;
    out_item_t           out_data_reg, out_data_next;

    logic [STORE_AW-1:0] wr_idx_reg, wr_idx_next;
    logic [2:0]          wr_bit_reg, wr_bit_next;
    logic                wr_col_reg, wr_col_next;
    logic                pend_cmd_reg, pend_cmd_next;
    logic [7:0]          pend_byte_reg, pend_byte_next;
    logic                pend_done_reg, pend_done_next;

    pix_loc_t            loc;
    logic                accept;
    logic                out_free;
    logic [5:0]          data_off;
    logic [7:0]          emit_byte;
    logic [7:0]          bit_mask;

    logic                ram_we;
    logic [STORE_AW-1:0] ram_wr_addr;
    logic [BYTE_W-1:0]   ram_wr_data;
    logic                ram_rd_en;
    logic [STORE_AW-1:0] ram_rd_addr;
    logic [BYTE_W-1:0]   ram_rd_data;

    mfs_addr u_addr (
        .rotation (rotation_reg),
        .pos_x    (in_data.pos_x),
        .pos_y    (in_data.pos_y),
        .loc      (loc)
    );

    mfs_ram #(
        .AW (STORE_AW),
        .DW (BYTE_W)
    ) u_ram (
        .clk     (clk),
        .we      (ram_we),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign data_off  = scan_step_reg - DATA_BASE;
    assign emit_byte = pend_cmd_reg ? pend_byte_reg : ram_rd_data;
    assign bit_mask  = 8'(1) << wr_bit_reg;

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        scan_row_next  = scan_row_reg;
        scan_step_next = scan_step_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        wr_idx_next    = wr_idx_reg;
        wr_bit_next    = wr_bit_reg;
        wr_col_next    = wr_col_reg;
        pend_cmd_next  = pend_cmd_reg;
        pend_byte_next = pend_byte_reg;
        pend_done_next = pend_done_reg;
        ram_we         = 1'b0;
        ram_wr_addr    = wr_idx_reg;
        ram_wr_data    = '0;
        ram_rd_en      = 1'b0;
        ram_rd_addr    = loc.idx;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_wr_addr  = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (&clr_cnt_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept && !sleep_reg)
                begin
                    if (in_data.mode == MODE_PIXEL)
                    begin
                        if (loc.in_bounds)
                        begin
                            ram_rd_en   = 1'b1;
                            wr_idx_next = loc.idx;
                            wr_bit_next = loc.bit_pos;
                            wr_col_next = in_data.colour ^ invert_reg;
                            state_next  = ST_PIX_WR;
                        end
                    end
                    else
                    begin
                        pend_cmd_next  = (scan_step_reg == STEP_ROW)
                                      || (scan_step_reg == STEP_COL);
                        pend_byte_next = (scan_step_reg == STEP_ROW)
                                       ? (ROW_CMD | {3'b000, scan_row_reg}) : COL_CMD;
                        ram_rd_en      = 1'b1;
                        ram_rd_addr    = {scan_row_reg, data_off[4:0]};
                        pend_done_next = 1'b0;
                        if (scan_step_reg == LAST_STEP)
                        begin
                            scan_step_next = '0;
                            if (scan_row_reg == LAST_ROW)
                            begin
                                pend_done_next = 1'b1;
                                scan_row_next  = '0;
                            end
                            else
                            begin
                                scan_row_next = scan_row_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            scan_step_next = scan_step_reg + 1'b1;
                        end
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_PIX_WR:
            begin
                ram_we      = 1'b1;
                ram_wr_addr = wr_idx_reg;
                ram_wr_data = wr_col_reg ? (ram_rd_data | bit_mask)
                                         : (ram_rd_data & ~bit_mask);
                state_next  = ST_IDLE;
            end
            ST_EMIT:
            begin
                // read data stays put: no further read until the next accept
                if (out_free)
                begin
                    out_valid_next             = 1'b1;
                    out_data_next.frame_word   = frame_of(pend_cmd_reg ? SYNC_CMD : SYNC_DATA,
                                                          emit_byte);
                    out_data_next.is_command   = pend_cmd_reg;
                    out_data_next.refresh_done = pend_done_reg;
                    state_next                 = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            scan_row_reg  <= '0;
            scan_step_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            scan_row_reg  <= scan_row_next;
            scan_step_reg <= scan_step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rotation_reg <= ROT_0;
            invert_reg   <= 1'b0;
            sleep_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ROTATION: rotation_reg <= cfg_data;
                REG_INVERT:   invert_reg   <= cfg_data[0];
                REG_SLEEPING: sleep_reg    <= cfg_data[0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        wr_idx_reg    <= wr_idx_next;
        wr_bit_reg    <= wr_bit_next;
        wr_col_reg    <= wr_col_next;
        pend_cmd_reg  <= pend_cmd_next;
        pend_byte_reg <= pend_byte_next;
        pend_done_reg <= pend_done_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        scan_step_reg <= LAST_STEP)
        else $error("refresh step past end of row");

    a_pix_wr_once: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_PIX_WR |=> state_reg == ST_IDLE)
        else $error("pixel write-back did not complete in one cycle");

    a_store_write_src: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_CLEAR || state_reg == ST_PIX_WR))
        else $error("store written outside clear or write-back");

    a_done_is_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.refresh_done |-> !out_data_reg.is_command
            && scan_row_reg == '0)
        else $error("refresh end flagged on a command frame");

    a_accept_emits: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !sleep_reg && in_data.mode == MODE_REFRESH |=> state_reg == ST_EMIT)
        else $error("refresh beat did not reach the emit state");

endmodule

// ===== hdl/mfs_ram.sv =====
// Generic single-clock RAM, one write and one registered read port.
// No dependencies.
module mfs_ram #(
    parameter int AW = 10,
    parameter int DW = 8
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [(1 << AW)];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/mfs_addr.sv =====
// Pixel address unit: rotation, bounds check and mapping onto the split half-screen layout.
// Depends on mfs_pkg.
module mfs_addr (
    input  logic [1:0]      rotation,
    input  logic [6:0]      pos_x,
    input  logic [6:0]      pos_y,
    output mfs_pkg::pix_loc_t loc
);
    import mfs_pkg::*;

    logic [6:0] px;
    logic [5:0] py;
    logic       in_bounds;

    always_comb
    begin
        if (rotation[0])
        begin
            in_bounds = (pos_x < 7'(SCREEN_HEIGHT));
        end
        else
        begin
            in_bounds = (pos_y < 7'(SCREEN_HEIGHT));
        end

        // only the in-bounds low bits matter once the check has passed
        case (rotation)
            ROT_90:
            begin
                px = ~pos_y;
                py = pos_x[5:0];
            end
            ROT_180:
            begin
                px = ~pos_x;
                py = ~pos_y[5:0];
            end
            ROT_270:
            begin
                px = pos_y;
                py = ~pos_x[5:0];
            end
            default:
            begin
                px = pos_x;
                py = pos_y[5:0];
            end
        endcase
    end

    // row, half-screen select, byte pair, byte within pair
    assign loc.in_bounds = in_bounds;
    assign loc.idx       = {py[4:0], py[5], px[6:3]};
    assign loc.bit_pos   = ~px[2:0];

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the frame buffer with serial scanout: directed and random pixel and refresh beats.
// Depends on hdl/mfs_pkg.sv and hdl/mono_framebuffer_serial_scanout.sv.
module tb_top;
    import mfs_pkg::*;

    localparam int CLK_HALF_NS    = 10;
    localparam int LIMIT_NS       = 10_000_000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int TAIL_CYCLES    = 16;
    localparam int DRAIN_LIMIT    = 20_000;
    localparam int HOLD_OFF_BEATS = 300;
    localparam int MAX_REPORTS    = 30;
    localparam int PHASE_ITEMS    = 300;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    in_item_t   in_data;
    logic       out_valid;
    logic       out_ready;
    out_item_t  out_data;
    logic       cfg_we;
    logic [1:0] cfg_index;
    logic [1:0] cfg_data;

    // predictor state
    logic [7:0] pix_mem [0:1023];
    logic [4:0] scan_row_q;
    logic [5:0] scan_step_q;
    logic [1:0] rot_cfg;
    logic       inv_cfg;
    logic       sleep_cfg;
    int         refresh_wraps;
    out_item_t  pending_frames[$];

    int   fault_count;
    int   send_idle_pct;
    int   recv_idle_pct;
    logic holding;
    event hold_off_go;

    mono_framebuffer_serial_scanout dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #(CLK_HALF_NS) clk = ~clk;

    task automatic flag_mismatch(input string msg);
        if (fault_count < MAX_REPORTS)
        begin
            $display("mismatch @%0t: %s", $realtime, msg);
        end
        fault_count++;
    endtask

    // Updates the pixel store, or the scan position plus a queued transfer, for one beat taken awake.
    task automatic track_frame_and_scan(input in_item_t item);
        int         lx;
        int         ly;
        int         px;
        int         py;
        logic [9:0] addr;
        logic [2:0] bit_sel;
        logic [7:0] payload;
        logic [7:0] sync;
        logic       in_view;
        out_item_t  res;
        if (sleep_cfg)
        begin
            return;
        end
        if (item.mode == MODE_PIXEL)
        begin
            lx = item.pos_x;
            ly = item.pos_y;
            in_view = rot_cfg[0] ? (lx < SCREEN_HEIGHT && ly < SCREEN_WIDTH)
                                 : (lx < SCREEN_WIDTH && ly < SCREEN_HEIGHT);
            if (!in_view)
            begin
                return;
            end
            case (rot_cfg)
                ROT_90:
                begin
                    px = SCREEN_WIDTH - 1 - ly;
                    py = lx;
                end
                ROT_180:
                begin
                    px = SCREEN_WIDTH - 1 - lx;
                    py = SCREEN_HEIGHT - 1 - ly;
                end
                ROT_270:
                begin
                    px = ly;
                    py = SCREEN_HEIGHT - 1 - lx;
                end
                default:
                begin
                    px = lx;
                    py = ly;
                end
            endcase
            // lower half of the panel lives in the second 16 bytes of each store row
            addr    = 10'(32 * (py % 32) + ((py >= 32) ? 16 : 0) + px / 8);
            bit_sel = 3'(7 - px % 8);
            pix_mem[addr][bit_sel] = item.colour ^ inv_cfg;
            return;
        end
        if (scan_step_q == STEP_ROW)
        begin
            payload = ROW_CMD | {3'b000, scan_row_q};
            sync    = SYNC_CMD;
        end
        else if (scan_step_q == STEP_COL)
        begin
            payload = COL_CMD;
            sync    = SYNC_CMD;
        end
        else
        begin
            payload = pix_mem[{scan_row_q, 5'(scan_step_q - DATA_BASE)}];
            sync    = SYNC_DATA;
        end
        res.frame_word   = {sync, payload[7:4], 4'h0, payload[3:0], 4'h0};
        res.is_command   = (sync == SYNC_CMD);
        res.refresh_done = (scan_step_q == LAST_STEP) && (scan_row_q == LAST_ROW);
        if (scan_step_q == LAST_STEP)
        begin
            scan_step_q = STEP_ROW;
            scan_row_q  = scan_row_q + 5'd1;
            if (res.refresh_done)
            begin
                refresh_wraps++;
            end
        end
        else
        begin
            scan_step_q = scan_step_q + 6'd1;
        end
        pending_frames.push_back(res);
    endtask

    task automatic check_frame(input out_item_t got);
        out_item_t want;
        if (pending_frames.size() == 0)
        begin
            flag_mismatch($sformatf("unexpected beat word=%h cmd=%b done=%b",
                                    got.frame_word, got.is_command, got.refresh_done));
            return;
        end
        want = pending_frames.pop_front();
        if (got.frame_word !== want.frame_word)
        begin
            flag_mismatch($sformatf("frame_word %h, want %h", got.frame_word, want.frame_word));
        end
        if (got.is_command !== want.is_command)
        begin
            flag_mismatch($sformatf("is_command %b, want %b", got.is_command, want.is_command));
        end
        if (got.refresh_done !== want.refresh_done)
        begin
            flag_mismatch($sformatf("refresh_done %b, want %b",
                                    got.refresh_done, want.refresh_done));
        end
    endtask

    // Called in the time step of a rising edge; returns in the step of the edge that takes the beat.
    task automatic offer_item(input in_item_t item);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
            begin
                @(posedge clk);
            end
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(negedge clk);
        while (!in_ready)
        begin
            @(negedge clk);
        end
        @(posedge clk);
        track_frame_and_scan(item);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (pending_frames.size() != 0)
        begin
            @(posedge clk);
        end
        // beats that give no transfer may still be in flight
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (index)
            REG_ROTATION: rot_cfg   = value;
            REG_INVERT:   inv_cfg   = value[0];
            REG_SLEEPING: sleep_cfg = value[0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    function automatic in_item_t make_item(input logic mode, input int x, input int y,
                                           input logic colour);
        in_item_t item;
        item.mode   = mode;
        item.pos_x  = 7'(x);
        item.pos_y  = 7'(y);
        item.colour = colour;
        return item;
    endfunction

    function automatic in_item_t random_item(input int refresh_pct);
        int x;
        int y;
        x = $urandom_range(127);
        y = $urandom_range(127);
        // mostly on-screen writes; the rest may fall off-screen and hit the bounds check
        if ($urandom_range(99) >= 15)
        begin
            if (rot_cfg[0])
            begin
                x = $urandom_range(SCREEN_HEIGHT - 1);
            end
            else
            begin
                y = $urandom_range(SCREEN_HEIGHT - 1);
            end
        end
        return make_item(($urandom_range(99) < refresh_pct) ? MODE_REFRESH : MODE_PIXEL,
                         x, y, 1'($urandom_range(1)));
    endfunction

    task automatic test_rotations();
        settle();
        write_reg(REG_ROTATION, ROT_90);
        offer_item(make_item(MODE_PIXEL, 63, 127, 1'b1));
        offer_item(make_item(MODE_PIXEL, 64, 0, 1'b1));
        settle();
        write_reg(REG_ROTATION, ROT_180);
        offer_item(make_item(MODE_PIXEL, 127, 63, 1'b1));
        offer_item(make_item(MODE_PIXEL, 0, 64, 1'b1));
        settle();
        write_reg(REG_ROTATION, ROT_270);
        offer_item(make_item(MODE_PIXEL, 63, 127, 1'b1));
        offer_item(make_item(MODE_PIXEL, 64, 127, 1'b1));
        settle();
        write_reg(REG_ROTATION, ROT_0);
    endtask

    task automatic test_invert();
        settle();
        write_reg(REG_INVERT, 2'd1);
        offer_item(make_item(MODE_PIXEL, 1, 0, 1'b0));
        offer_item(make_item(MODE_PIXEL, 2, 0, 1'b1));
        settle();
        write_reg(REG_INVERT, 2'd0);
    endtask

    task automatic test_sleep();
        settle();
        write_reg(REG_SLEEPING, 2'd1);
        offer_item(make_item(MODE_PIXEL, 3, 0, 1'b1));
        offer_item(make_item(MODE_REFRESH, 0, 0, 1'b0));
        settle();
        write_reg(REG_SLEEPING, 2'd0);
    endtask

    // Corner, half-boundary and off-screen writes, then the start of a refresh reads back the first two bytes of row 0.
    task automatic test_pixel_layout();
        offer_item(make_item(MODE_PIXEL, 0, 0, 1'b1));
        offer_item(make_item(MODE_PIXEL, 127, 63, 1'b1));
        offer_item(make_item(MODE_PIXEL, 8, 0, 1'b1));
        offer_item(make_item(MODE_PIXEL, 0, 32, 1'b1));
        offer_item(make_item(MODE_PIXEL, 0, 64, 1'b1));
        offer_item(make_item(MODE_PIXEL, 127, 127, 1'b1));
        offer_item(make_item(MODE_PIXEL, 127, 63, 1'b0));
        repeat (4) offer_item(make_item(MODE_REFRESH, 127, 127, 1'b1));
        settle();
    endtask

    task automatic test_random_phase(input int send_pct, input int recv_pct,
                                     input logic [1:0] rot, input logic inv);
        settle();
        write_reg(REG_ROTATION, rot);
        write_reg(REG_INVERT, {1'b0, inv});
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (PHASE_ITEMS) offer_item(random_item(90));
        settle();
    endtask

    task automatic test_backpressure();
        settle();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        -> hold_off_go;
        repeat (40) offer_item(random_item(100));
        settle();
    endtask

    task automatic test_refresh_wrap();
        int start_wraps;
        settle();
        write_reg(REG_ROTATION, ROT_0);
        write_reg(REG_INVERT, 2'd0);
        start_wraps = refresh_wraps;
        while (refresh_wraps == start_wraps)
        begin
            offer_item(random_item(95));
        end
        repeat (20) offer_item(random_item(80));
    endtask

    // long receiver stall, timed on falling edges so the ready process sees a settled flag
    initial
    begin
        holding = 1'b0;
        forever
        begin
            @(hold_off_go);
            @(negedge clk);
            holding = 1'b1;
            repeat (HOLD_OFF_BEATS) @(negedge clk);
            holding = 1'b0;
        end
    end

    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            out_ready <= !holding && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // handshake values are stable by the falling edge; the beat is taken at the next rising one
    always @(negedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            check_frame(out_data);
        end
    end

    initial
    begin
        #(LIMIT_NS);
        $display("[mono_framebuffer_serial_scanout] ERROR");
        $finish;
    end

    initial
    begin
        int drain_cycles;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_data       = '0;
        cfg_we        = 1'b0;
        cfg_index     = REG_ROTATION;
        cfg_data      = '0;
        fault_count   = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        refresh_wraps = 0;
        scan_row_q    = '0;
        scan_step_q   = STEP_ROW;
        rot_cfg       = ROT_0;
        inv_cfg       = 1'b0;
        sleep_cfg     = 1'b0;
        foreach (pix_mem[i])
        begin
            pix_mem[i] = '0;
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        // store clear runs now; register writes are taken meanwhile
        write_reg(REG_ROTATION, ROT_0);
        write_reg(REG_INVERT, 2'd0);
        write_reg(REG_SLEEPING, 2'd0);

        test_rotations();
        test_invert();
        test_sleep();
        test_pixel_layout();
        test_random_phase(30, 59, ROT_270, 1'b1);
        test_random_phase(59, 30, ROT_90, 1'b0);
        test_random_phase(0, 0, ROT_180, 1'b1);
        test_backpressure();
        test_refresh_wrap();

        in_valid <= 1'b0;
        drain_cycles = 0;
        while (pending_frames.size() != 0 && drain_cycles < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain_cycles++;
        end
        foreach (pending_frames[i])
        begin
            flag_mismatch($sformatf("transfer never arrived: word=%h",
                                    pending_frames[i].frame_word));
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fault_count == 0)
        begin
            $display("[mono_framebuffer_serial_scanout] OK");
        end
        else
        begin
            $display("[mono_framebuffer_serial_scanout] ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/mfs_pkg.sv
hdl/mfs_ram.sv
hdl/mfs_addr.sv
hdl/mono_framebuffer_serial_scanout.sv
sim/tb_top.sv
